// ===== hw/rtl/lstk_pkg.sv =====
// ----------------------------------------------------------------------------
// lstk_pkg
// Shared types and codes for the LIFO stack with indexed access.
// ----------------------------------------------------------------------------
package lstk_pkg;

    // Operation codes carried on the input transaction
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_CHANGE = 2'd3
    } t_op;

    // Error codes reported with each result
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } t_err;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned COUNT_W = 4;

    // Result sideband, travels with the memory read
    typedef struct packed {
        logic                 take_data;  // data comes from the memory read
        logic [COUNT_W-1:0]   count;
        logic                 empty;
        logic                 full;
        t_err                 error;
    } t_rsp_info;

endpackage

// ===== hw/rtl/lifo_stack_with_indexed_access.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_indexed_access
// Fixed-depth LIFO stack of signed 32-bit words with push, pop, peek at a
// position and change at a position. One result per operation.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_op, i_value, i_position
//   out     | output    | o_out_valid / i_out_stall| o_data, o_count, o_empty_res,
//           |           |                          | o_full_res, o_error
//
// One operation per cycle while input is not stalled; each result passes
// the read stage, where the sideband waits beside the registered read
// port of the stack memory, and then the output register. After reset a
// clearing sweep writes zeros to every address; input is stalled during it.
// A stalled output holds one result in the output register and one in the
// read stage; outside the sweep, input stalls only when both are full.
// ----------------------------------------------------------------------------
module lifo_stack_with_indexed_access #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic signed [31:0]                  i_value,
    input  logic [2:0]                          i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [31:0]                  o_data,
    output logic [3:0]                          o_count,
    output logic                                o_empty_res,
    output logic                                o_full_res,
    output logic [1:0]                          o_error
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                         take_ok;
    logic                         issue;
    lstk_pkg::t_rsp_info          ctrl_info;
    lstk_pkg::t_rsp_info          out_info;
    logic                         we, re;
    logic [AW-1:0]                waddr, raddr;
    logic [lstk_pkg::DATA_W-1:0]  wdata, rdata;

    // Control and decode
    lstk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_position (i_position),
        .i_take_ok  (take_ok),
        .o_issue    (issue),
        .o_info     (ctrl_info),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr)
    );

    // Stack store
    lstk_ram #(
        .WIDTH (lstk_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Result staging
    lstk_resp u_resp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_info      (ctrl_info),
        .i_rdata     (rdata),
        .o_take_ok   (take_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_info      (out_info)
    );

    assign o_count     = out_info.count;
    assign o_empty_res = out_info.empty;
    assign o_full_res  = out_info.full;
    assign o_error     = out_info.error;

    // Clearing sweep blocks input right after reset
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("input accepted during clearing sweep");

    // Overflow only when full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error == lstk_pkg::ERR_OVERFLOW)) |-> o_full_res)
        else $error("overflow reported while not full");

    // Underflow only when empty, with zero data
    a_unf_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error == lstk_pkg::ERR_UNDERFLOW))
            |-> (o_empty_res && (o_data == '0)))
        else $error("underflow result inconsistent");

    // Full flag agrees with the count field
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_full_res) |-> (o_count == 4'(DEPTH) && !o_empty_res))
        else $error("full flag disagrees with count");

endmodule

// ===== hw/rtl/lstk_ram.sv =====
// ----------------------------------------------------------------------------
// lstk_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// A read and a write to the same address in one cycle return the old word.
// ----------------------------------------------------------------------------
module lstk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage and registered read (read-first)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lstk_ctrl.sv =====
// ----------------------------------------------------------------------------
// lstk_ctrl
// Stack control: fill count, operation decode, memory read/write issue and
// the clearing sweep after reset.
// ----------------------------------------------------------------------------
module lstk_ctrl #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input transaction
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_op,
    input  logic signed [lstk_pkg::DATA_W-1:0] i_value,
    input  logic [lstk_pkg::POS_W-1:0]       i_position,
    // from the response stage
    input  logic                             i_take_ok,
    output logic                             o_issue,
    output lstk_pkg::t_rsp_info              o_info,
    // memory ports
    output logic                             o_we,
    output logic [$clog2(DEPTH)-1:0]         o_waddr,
    output logic [lstk_pkg::DATA_W-1:0]      o_wdata,
    output logic                             o_re,
    output logic [$clog2(DEPTH)-1:0]         o_raddr
);

    localparam int unsigned AW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH + 1);
    localparam int unsigned XW  = ((AW > lstk_pkg::POS_W) ? AW : lstk_pkg::POS_W) + 1;
    localparam int unsigned CXW = (CW > lstk_pkg::COUNT_W) ? CW : lstk_pkg::COUNT_W;

    logic [CW-1:0] r_count, n_count;
    logic          r_clearing, n_clearing;
    logic [AW-1:0] r_clr_addr, n_clr_addr;

    logic          accept;
    logic          full, empty;
    logic          pos_ok;
    logic [AW-1:0] pos_a;
    logic [AW-1:0] top_a;
    logic [CW-1:0] count_dec;
    lstk_pkg::t_op op;

    assign op        = lstk_pkg::t_op'(i_op);
    assign accept    = i_in_valid && !r_clearing && i_take_ok;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign pos_ok    = (XW'(i_position) < XW'(DEPTH));
    assign pos_a     = AW'(i_position);
    assign top_a     = AW'(r_count);
    assign count_dec = r_count - CW'(1);

    assign o_in_stall = r_clearing || !i_take_ok;
    assign o_issue    = accept;

    // Decode one operation, drive memory and next count
    always_comb begin
        n_count        = r_count;
        n_clearing     = r_clearing;
        n_clr_addr     = r_clr_addr;
        o_we           = 1'b0;
        o_waddr        = top_a;
        o_wdata        = '0;
        o_re           = 1'b0;
        o_raddr        = pos_a;
        o_info.take_data = 1'b0;
        o_info.error     = lstk_pkg::ERR_NONE;

        if (r_clearing) begin
            // sweep zeros through the store
            o_we    = 1'b1;
            o_waddr = r_clr_addr;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                n_clearing = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + AW'(1);
            end
        end else if (accept) begin
            unique case (op)
                lstk_pkg::OP_PUSH: begin
                    if (full) begin
                        o_info.error = lstk_pkg::ERR_OVERFLOW;
                    end else begin
                        o_we    = 1'b1;
                        o_waddr = top_a;
                        o_wdata = i_value;
                        n_count = r_count + CW'(1);
                    end
                end
                lstk_pkg::OP_POP: begin
                    if (empty) begin
                        o_info.error = lstk_pkg::ERR_UNDERFLOW;
                    end else begin
                        // read old top and zero it in the same cycle
                        o_re             = 1'b1;
                        o_raddr          = AW'(count_dec);
                        o_we             = 1'b1;
                        o_waddr          = AW'(count_dec);
                        n_count          = count_dec;
                        o_info.take_data = 1'b1;
                    end
                end
                lstk_pkg::OP_PEEK: begin
                    if (empty) begin
                        o_info.error = lstk_pkg::ERR_UNDERFLOW;
                    end else if (pos_ok) begin
                        o_re             = 1'b1;
                        o_raddr          = pos_a;
                        o_info.take_data = 1'b1;
                    end
                end
                lstk_pkg::OP_CHANGE: begin
                    if (pos_ok) begin
                        o_we    = 1'b1;
                        o_waddr = pos_a;
                        o_wdata = i_value;
                    end
                end
                default: begin
                end
            endcase
        end

        // Flags and count seen after the operation
        o_info.count = lstk_pkg::COUNT_W'(CXW'(n_count));
        o_info.empty = (n_count == '0);
        o_info.full  = (n_count == CW'(DEPTH));
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_count    <= n_count;
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

endmodule

// ===== hw/rtl/lstk_resp.sv =====
// ----------------------------------------------------------------------------
// lstk_resp
// Response path: holds the sideband while the memory read completes, then
// loads the output register. Read data stays valid in the RAM until the
// next read, so a stalled read stage simply holds.
// ----------------------------------------------------------------------------
module lstk_resp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_issue,
    input  lstk_pkg::t_rsp_info                  i_info,
    input  logic [lstk_pkg::DATA_W-1:0]          i_rdata,
    output logic                                 o_take_ok,
    // output transaction
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [lstk_pkg::DATA_W-1:0]   o_data,
    output lstk_pkg::t_rsp_info                  o_info
);

    logic                          r_s1_v;
    lstk_pkg::t_rsp_info           r_s1_info;
    logic                          r_out_v;
    lstk_pkg::t_rsp_info           r_out_info;
    logic [lstk_pkg::DATA_W-1:0]   r_out_data;
    logic                          s1_adv;

    assign s1_adv    = r_s1_v && (!r_out_v || !i_out_stall);
    assign o_take_ok = !r_s1_v || s1_adv;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_issue) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1_info <= i_info;
        end
        if (s1_adv) begin
            r_out_info <= r_s1_info;
            r_out_data <= r_s1_info.take_data ? i_rdata : '0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_data      = r_out_data;
    assign o_info      = r_out_info;

endmodule

// ===== verif/lstk_stack_checker.sv =====
// ----------------------------------------------------------------------------
// lstk_stack_checker
// Watches both channels of the LIFO stack, keeps its own copy of the stack
// and the fill count, predicts one result per accepted operation, and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lstk_stack_checker #(
    parameter int unsigned DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel as seen at the block
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value,
    input  logic [2:0]         i_position,
    // output channel as seen at the block
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_data,
    input  logic [3:0]         i_count,
    input  logic               i_empty_res,
    input  logic               i_full_res,
    input  logic [1:0]         i_error,
    // status toward the testbench top
    output int unsigned        o_fail_count,
    output int unsigned        o_pending
);

    import lstk_pkg::*;

    // One predicted result
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic                     empty;
        logic                     full;
        t_err                     error;
    } t_stack_result;

    // Predictor state
    logic signed [DATA_W-1:0] model_store [DEPTH];
    int unsigned              model_fill;

    t_stack_result            expected_results [$];
    int unsigned              fail_total;
    int unsigned              result_idx;

    assign o_fail_count = fail_total;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, result_idx, msg);
        fail_total++;
    endtask

    // Apply one operation to the predictor, return the result it causes
    task automatic predict_stack_op(
        input  t_op                      op,
        input  logic signed [DATA_W-1:0] value,
        input  logic [POS_W-1:0]         pos,
        output t_stack_result            res
    );
        res = '0;
        case (op)
            OP_PUSH: begin
                if (model_fill >= DEPTH) begin
                    res.error = ERR_OVERFLOW;
                end else begin
                    model_store[model_fill] = value;
                    model_fill++;
                end
            end
            OP_POP: begin
                if (model_fill == 0) begin
                    res.error = ERR_UNDERFLOW;
                end else begin
                    model_fill--;
                    res.data = model_store[model_fill];
                    model_store[model_fill] = '0;
                end
            end
            OP_PEEK: begin
                if (model_fill == 0) begin
                    res.error = ERR_UNDERFLOW;
                end else if (pos < DEPTH) begin
                    res.data = model_store[pos];
                end
            end
            default: begin
                // change: count untouched, out-of-range positions ignored
                if (pos < DEPTH) begin
                    model_store[pos] = value;
                end
            end
        endcase
        res.count = model_fill[COUNT_W-1:0];
        res.empty = (model_fill == 0);
        res.full  = (model_fill == DEPTH);
    endtask

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_stack_result pred;
        t_stack_result exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                model_store[i] = '0;
            end
            model_fill = 0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_stack_op(t_op'(i_op), i_value, i_position, pred);
                expected_results.push_back(pred);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no operation outstanding");
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_data !== exp_res.data)
                        report_mismatch($sformatf("data got %0d expected %0d",
                                                  i_data, exp_res.data));
                    if (i_count !== exp_res.count)
                        report_mismatch($sformatf("count got %0d expected %0d",
                                                  i_count, exp_res.count));
                    if (i_empty_res !== exp_res.empty)
                        report_mismatch($sformatf("empty got %b expected %b",
                                                  i_empty_res, exp_res.empty));
                    if (i_full_res !== exp_res.full)
                        report_mismatch($sformatf("full got %b expected %b",
                                                  i_full_res, exp_res.full));
                    if (i_error !== exp_res.error)
                        report_mismatch($sformatf("error got %0d expected %0d",
                                                  i_error, exp_res.error));
                end
                result_idx++;
            end
            o_pending <= expected_results.size();
        end
    end

    initial begin
        fail_total = 0;
        result_idx = 0;
        model_fill = 0;
    end

endmodule

// ===== verif/lifo_stack_with_indexed_access_tb.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_indexed_access_tb
// Drives push, pop, peek and change transactions into the LIFO stack with
// random gaps and output stalls; a directed opening covers empty and full
// corners, then random bursts sweep the fill level up and down.
// ----------------------------------------------------------------------------
module lifo_stack_with_indexed_access_tb;

    import lstk_pkg::*;

    localparam int unsigned DEPTH      = 8;
    localparam int unsigned RAND_ITEMS = 1400;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_op;
    logic signed [31:0] i_value;
    logic [2:0]         i_position;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_data;
    logic [3:0]         o_count;
    logic               o_empty_res;
    logic               o_full_res;
    logic [1:0]         o_error;

    int unsigned        fail_count;
    int unsigned        pending;
    bit                 no_gaps;

    lifo_stack_with_indexed_access #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_count     (o_count),
        .o_empty_res (o_empty_res),
        .o_full_res  (o_full_res),
        .o_error     (o_error)
    );

    lstk_stack_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_data       (o_data),
        .i_count      (o_count),
        .i_empty_res  (o_empty_res),
        .i_full_res   (o_full_res),
        .i_error      (o_error),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none, some short, a few long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)      return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 10);
        else             return $urandom_range(20, 60);
    endfunction

    // Data word: mostly random, sometimes an extreme
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // One transaction on the input channel, then an optional gap
    task automatic send_op(input t_op op, input logic signed [31:0] value,
                           input logic [2:0] pos);
        int unsigned n;
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        n = no_gaps ? 0 : gap_len();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold the input idle until every predicted result has arrived
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Output stall: free-running stretches, random stalls, long holds
    initial begin
        int unsigned r;
        int unsigned len;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                len = $urandom_range(1, 40);
                repeat (len) begin
                    i_out_stall <= 1'b0;
                    @(posedge i_clk);
                end
            end else if (r < 9) begin
                len = $urandom_range(1, 30);
                repeat (len) begin
                    i_out_stall <= ($urandom_range(0, 2) == 0);
                    @(posedge i_clk);
                end
            end else begin
                len = $urandom_range(20, 60);
                repeat (len) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned mode;
        int unsigned r;
        t_op         op;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= OP_PUSH;
        i_value    <= '0;
        i_position <= '0;
        no_gaps     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty corners, fill to full, overflow, drain, above-top access
        send_op(OP_POP,    32'sd0,         3'd0);
        send_op(OP_PEEK,   32'sd0,         3'd0);
        send_op(OP_CHANGE, 32'sh7FFF_FFFF, 3'd7);
        send_op(OP_PEEK,   32'sd0,         3'd7);
        send_op(OP_PUSH,   32'sh7FFF_FFFF, 3'd0);
        send_op(OP_PUSH,   32'sh8000_0000, 3'd7);
        send_op(OP_PUSH,   -32'sd1,        3'd5);
        send_op(OP_PUSH,   32'sd0,         3'd2);
        send_op(OP_PUSH,   32'sd1,         3'd1);
        send_op(OP_PUSH,   32'sh5555_5555, 3'd6);
        send_op(OP_PUSH,   32'shAAAA_AAAA, 3'd3);
        send_op(OP_PUSH,   32'sh1234_5678, 3'd4);
        send_op(OP_PUSH,   32'sh0BAD_F00D, 3'd0);
        send_op(OP_PEEK,   32'sd0,         3'd0);
        send_op(OP_PEEK,   32'sd0,         3'd7);
        send_op(OP_CHANGE, 32'shDEAD_BEEF, 3'd3);
        send_op(OP_PEEK,   32'sd0,         3'd3);
        repeat (DEPTH) send_op(OP_POP, 32'sd0, 3'd0);
        send_op(OP_POP,    32'sd0,         3'd0);
        send_op(OP_PUSH,   32'sh0000_00A5, 3'd0);
        send_op(OP_CHANGE, 32'sh7654_3210, 3'd6);
        send_op(OP_PEEK,   32'sd0,         3'd6);
        send_op(OP_PEEK,   32'sd0,         3'd5);
        wait_drained();

        // Random bursts: filling, draining or mixed, some with no gaps
        sent = 0;
        while (sent < RAND_ITEMS) begin
            mode    = $urandom_range(0, 2);
            burst   = $urandom_range(20, 60);
            no_gaps = ($urandom_range(0, 9) < 3);
            repeat (burst) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0:       op = (r < 60) ? OP_PUSH : (r < 75) ? OP_POP :
                                  (r < 90) ? OP_PEEK : OP_CHANGE;
                    1:       op = (r < 60) ? OP_POP : (r < 75) ? OP_PUSH :
                                  (r < 90) ? OP_PEEK : OP_CHANGE;
                    default: op = t_op'(r % 4);
                endcase
                send_op(op, pick_word(), 3'($urandom_range(0, 7)));
                sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end

        // Let the last results come out before the verdict
        no_gaps = 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Timeout
    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
